@@ rtl/scba_pkg.sv @@
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types, codes and constant tables of the size-class pool allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

	// Fixed field widths
	localparam int SIZE_W  = 32;
	localparam int IDX_W   = 7;
	localparam int CNT_W   = IDX_W + 1;  // holds pool size itself
	localparam int CFG_W   = 3;

	// Register file and queue sizing
	localparam int NUM_CLASS_REGS = 7;
	localparam int QUEUE_DEPTH    = 2;

	// Default sizing
	localparam int DEF_POOL_BUFFERS = 71;
	localparam int DEF_SIZE_CLASSES = 7;

	// Command codes
	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		ST_GRANTED   = 2'd0,
		ST_NO_FREE   = 2'd1,
		ST_RELEASED  = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	// Work kind decided by the front end
	typedef enum logic [1:0] {
		K_SCAN    = 2'd0,  // allocate, scan from idx
		K_FREE    = 2'd1,  // release idx
		K_BAD_IDX = 2'd2,  // release index out of range
		K_NO_FREE = 2'd3   // allocate with nothing to scan
	} kind_t;

	// Queue entry between front and back
	typedef struct packed {
		kind_t              kind;
		logic [CNT_W-1:0]   idx;
	} work_t;

	// First pool index of each class
	function automatic logic [CNT_W-1:0] class_start(input logic [CFG_W-1:0] c);
		logic [CNT_W-1:0] s;
		unique case (c)
			3'd0:    s = 8'd0;
			3'd1:    s = 8'd16;
			3'd2:    s = 8'd48;
			3'd3:    s = 8'd56;
			3'd4:    s = 8'd64;
			3'd5:    s = 8'd68;
			3'd6:    s = 8'd70;
			default: s = 8'd128;
		endcase
		return s;
	endfunction

	// Class byte size after reset
	function automatic logic [SIZE_W-1:0] class_size_reset(input logic [CFG_W-1:0] c);
		logic [SIZE_W-1:0] s;
		unique case (c)
			3'd0:    s = 32'd65536;
			3'd1:    s = 32'd524288;
			3'd2:    s = 32'd1048576;
			3'd3:    s = 32'd4194304;
			3'd4:    s = 32'd8388608;
			3'd5:    s = 32'd16777216;
			3'd6:    s = 32'd33554432;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

@@ rtl/scba_front.sv @@
// ----------------------------------------------------------------------------
// scba_front
// Holds the class size registers and classifies each request into a work
// entry: scan start for allocate, range check for release.
// ----------------------------------------------------------------------------
module scba_front
	import scba_pkg::*;
#(
	parameter int POOL_BUFFERS = DEF_POOL_BUFFERS,
	parameter int SIZE_CLASSES = DEF_SIZE_CLASSES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [CFG_W-1:0]  cfg_index,
	input  logic [SIZE_W-1:0] cfg_data,
	input  logic              command,
	input  logic [SIZE_W-1:0] request_bytes,
	input  logic [IDX_W-1:0]  release_index,
	output work_t             entry
);

	logic [SIZE_W-1:0] size_q [NUM_CLASS_REGS];
	logic [CNT_W-1:0]  start;

	// Class size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASS_REGS; i++) begin
				size_q[i] <= class_size_reset(CFG_W'(i));
			end
		end else if (cfg_valid && (cfg_index < CFG_W'(NUM_CLASS_REGS))) begin
			size_q[cfg_index] <= cfg_data;
		end
	end

	// First class that fits wins; walk backwards so the lowest overrides
	always_comb begin
		start = CNT_W'(POOL_BUFFERS);
		for (int c = SIZE_CLASSES - 1; c >= 0; c--) begin
			if (size_q[c] >= request_bytes) begin
				start = class_start(CFG_W'(c));
			end
		end
	end

	// Build the work entry
	always_comb begin
		if (command == CMD_RELEASE) begin
			entry.idx = {1'b0, release_index};
			if ({1'b0, release_index} < CNT_W'(POOL_BUFFERS)) begin
				entry.kind = K_FREE;
			end else begin
				entry.kind = K_BAD_IDX;
			end
		end else begin
			entry.idx = start;
			if (start < CNT_W'(POOL_BUFFERS)) begin
				entry.kind = K_SCAN;
			end else begin
				entry.kind = K_NO_FREE;
			end
		end
	end

endmodule

@@ rtl/scba_queue.sv @@
// ----------------------------------------------------------------------------
// scba_queue
// Two-entry queue of work entries between front and back end.
// ----------------------------------------------------------------------------
module scba_queue
	import scba_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  work_t push_entry,
	output logic  not_full,
	input  logic  pop,
	output logic  not_empty,
	output work_t pop_entry
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	work_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	assign not_full  = (fill_q != FILL_W'(QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign pop_entry = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push && not_full) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push && not_full) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && not_empty) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push && not_full, pop && not_empty})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

@@ rtl/scba_back.sv @@
// ----------------------------------------------------------------------------
// scba_back
// Owns the in-use flags. Releases finish at the pop; allocations scan
// one flag per cycle from the class start to a free flag or the pool end.
// ----------------------------------------------------------------------------
module scba_back
	import scba_pkg::*;
#(
	parameter int POOL_BUFFERS = DEF_POOL_BUFFERS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  work_t            q_entry,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       status,
	output logic [IDX_W-1:0] granted_index
);

	localparam int PTR_W = (POOL_BUFFERS > 1) ? $clog2(POOL_BUFFERS) : 1;

	typedef enum logic {S_IDLE, S_SCAN} state_t;

	state_t                  state_q;
	logic [POOL_BUFFERS-1:0] flags_q;
	logic [PTR_W-1:0]        ptr_q;
	logic                    slot_free;
	logic                    res_load;
	status_t                 status_q;

	assign slot_free = !out_valid || out_ready;
	assign q_pop     = (state_q == S_IDLE) && q_valid && slot_free;
	assign status    = status_q;

	// A result is produced this cycle: non-scan kinds at pop, or scan end
	assign res_load = (q_pop && (q_entry.kind != K_SCAN)) ||
		((state_q == S_SCAN) &&
		(!flags_q[ptr_q] || (ptr_q == PTR_W'(POOL_BUFFERS - 1))));

	// Sequencer, flags and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			flags_q       <= '0;
			ptr_q         <= '0;
			out_valid     <= 1'b0;
			status_q      <= ST_GRANTED;
			granted_index <= '0;
		end else begin
			// New result replaces the one taken in the same cycle
			if (res_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						unique case (q_entry.kind)
							K_SCAN: begin
								ptr_q   <= q_entry.idx[PTR_W-1:0];
								state_q <= S_SCAN;
							end
							K_FREE: begin
								flags_q[q_entry.idx[PTR_W-1:0]] <= 1'b0;
								status_q      <= ST_RELEASED;
								granted_index <= '0;
							end
							K_BAD_IDX: begin
								status_q      <= ST_BAD_INDEX;
								granted_index <= '0;
							end
							K_NO_FREE: begin
								status_q      <= ST_NO_FREE;
								granted_index <= '0;
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					// Slot is free here: nothing fills it while scanning
					if (!flags_q[ptr_q]) begin
						flags_q[ptr_q] <= 1'b1;
						status_q       <= ST_GRANTED;
						granted_index  <= IDX_W'(ptr_q);
						state_q        <= S_IDLE;
					end else if (ptr_q == PTR_W'(POOL_BUFFERS - 1)) begin
						status_q      <= ST_NO_FREE;
						granted_index <= '0;
						state_q       <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A scan never starts while an undelivered result is pending
	a_scan_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !out_valid)
		else $error("scan running with result pending");

	// A granted buffer is marked used right after the grant
	a_grant_marks: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SCAN) && !flags_q[ptr_q]) |=> flags_q[$past(ptr_q)])
		else $error("granted buffer not marked used");

	// Non-grant results carry a zero index
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status_q != ST_GRANTED)) |-> (granted_index == '0))
		else $error("index set on non-grant result");

	// Granted index lies inside the pool
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status_q == ST_GRANTED)) |->
		({1'b0, granted_index} < CNT_W'(POOL_BUFFERS)))
		else $error("granted index beyond pool");

endmodule

@@ rtl/size_class_buffer_pool_allocator_core.sv @@
// ----------------------------------------------------------------------------
// size_class_buffer_pool_allocator_core
// Allocator over a pool of buffers grouped into ascending size classes.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: cfg_index 0..6 selects a class size register, cfg_data is
//   its byte size; always ready, write only while the block is idle.
//   in channel: command 0 allocates a buffer of request_bytes, command 1
//   releases buffer release_index. Accepted while the two-entry work queue
//   has room.
//   out channel: status and granted_index, one result per request, in
//   request order, held until taken.
// Flow: each request is classified by the front end and stored in the work
//   queue; a release or a rejected allocate has its result registered at
//   the edge it leaves the queue. An allocate scans one in-use flag per
//   cycle from its class start and its result is registered when a free
//   flag is found or the last flag of the pool is examined. The back end
//   takes a new entry only when idle, so later requests wait in the queue.
// Reset: all buffers free, class sizes back to their defaults, queue empty.
// Stall: a result not taken holds the back end; the queue keeps accepting
//   up to two more requests, then in_ready drops.
// ----------------------------------------------------------------------------
module size_class_buffer_pool_allocator_core
	import scba_pkg::*;
#(
	parameter int POOL_BUFFERS = DEF_POOL_BUFFERS,
	parameter int SIZE_CLASSES = DEF_SIZE_CLASSES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_index,
	input  logic [SIZE_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              command,
	input  logic [SIZE_W-1:0] request_bytes,
	input  logic [IDX_W-1:0]  release_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [IDX_W-1:0]  granted_index
);

	work_t front_entry;
	work_t back_entry;
	logic  q_not_full;
	logic  q_not_empty;
	logic  q_pop;

	assign cfg_ready = 1'b1;
	assign in_ready  = q_not_full;

	// Classify requests
	scba_front #(
		.POOL_BUFFERS(POOL_BUFFERS),
		.SIZE_CLASSES(SIZE_CLASSES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (command),
		.request_bytes(request_bytes),
		.release_index(release_index),
		.entry        (front_entry)
	);

	// Decoupling queue
	scba_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_entry(front_entry),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_entry (back_entry)
	);

	// Execute against the flags
	scba_back #(
		.POOL_BUFFERS(POOL_BUFFERS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_not_empty),
		.q_entry      (back_entry),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.granted_index(granted_index)
	);

endmodule

@@ sim/size_class_buffer_pool_allocator_core_tb.sv @@
// ----------------------------------------------------------------------------
// size_class_buffer_pool_allocator_core_tb
// Self-checking bench for the size-class pool allocator. Allocate and release
// requests go in through valid/ready with bursty timing. A tracker keeps its
// own copy of the in-use flags and class sizes and predicts the status and
// granted index of each request. Every result is checked in order.
// ----------------------------------------------------------------------------
module size_class_buffer_pool_allocator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import scba_pkg::*;

	localparam int POOL_SIZE    = 71;
	localparam int CLASS_COUNT  = 7;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 96;
	localparam int HOLD_CYCLES  = 400;            // long receiver hold-off
	localparam int STALL_LIMIT  = 3000;           // cycles with no handshake
	localparam int DRAIN_CYCLES = 2 * POOL_SIZE + 10;

	localparam logic [SIZE_W-1:0] DEFAULT_BYTES [NUM_CLASS_REGS] = '{
		32'd65536, 32'd524288, 32'd1048576, 32'd4194304,
		32'd8388608, 32'd16777216, 32'd33554432
	};
	// first pool index of each class
	localparam int CLASS_BASE [NUM_CLASS_REGS] = '{0, 16, 48, 56, 64, 68, 70};

	typedef struct packed {
		status_t          st;
		logic [IDX_W-1:0] idx;
	} alloc_result_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_EVERY_THIRD} rx_mode_t;

	// Tracks buffer ownership and class sizes, holds results still to come
	class pool_tracker;
		logic [SIZE_W-1:0] class_bytes [NUM_CLASS_REGS];
		bit                in_use [POOL_SIZE];
		alloc_result_t     awaited [$];
		int                errors;

		function new();
			foreach (class_bytes[c]) class_bytes[c] = DEFAULT_BYTES[c];
			foreach (in_use[i]) in_use[i] = 1'b0;
			errors = 0;
		endfunction

		function void write_class(logic [CFG_W-1:0] r, logic [SIZE_W-1:0] bytes);
			if (r < NUM_CLASS_REGS) class_bytes[r] = bytes;
		endfunction

		// Predict the result of one accepted request and update the flags
		function void note_request(logic cmd, logic [SIZE_W-1:0] bytes,
				logic [IDX_W-1:0] rel);
			alloc_result_t r;
			int            scan_from;
			bit            matched;
			r.st  = ST_NO_FREE;
			r.idx = '0;
			if (cmd == CMD_RELEASE) begin
				if (rel < POOL_SIZE) begin
					in_use[rel] = 1'b0;
					r.st = ST_RELEASED;
				end else begin
					r.st = ST_BAD_INDEX;
				end
			end else begin
				// first class large enough, taken in register order
				scan_from = POOL_SIZE;
				matched = 1'b0;
				for (int c = 0; c < CLASS_COUNT; c++) begin
					if (!matched && class_bytes[c] >= bytes) begin
						scan_from = CLASS_BASE[c];
						matched = 1'b1;
					end
				end
				// lowest free buffer from there to the end of the pool
				for (int i = scan_from; i < POOL_SIZE; i++) begin
					if (r.st != ST_GRANTED && !in_use[i]) begin
						in_use[i] = 1'b1;
						r.st = ST_GRANTED;
						r.idx = IDX_W'(i);
					end
				end
			end
			awaited.insert(awaited.size(), r);
		endfunction

		function void report_error(string msg);
			errors++;
			if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
		endfunction

		function void check_result(status_t st, logic [IDX_W-1:0] idx);
			alloc_result_t want;
			if (awaited.size() == 0) begin
				report_error($sformatf("result with none awaited: status %0d index %0d",
					st, idx));
				return;
			end
			want = awaited.pop_front();
			if (st !== want.st)
				report_error($sformatf("status expected %s got %0d", want.st.name(), st));
			if (idx !== want.idx)
				report_error($sformatf("granted_index expected %0d got %0d", want.idx, idx));
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// a buffer currently held, picked at random; -1 when none is held
		function int pick_held();
			int start;
			int found;
			start = $urandom_range(0, POOL_SIZE - 1);
			found = -1;
			for (int k = 0; k < POOL_SIZE; k++) begin
				if (found < 0 && in_use[(start + k) % POOL_SIZE]) found = (start + k) % POOL_SIZE;
			end
			return found;
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_index;
	logic [SIZE_W-1:0] cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic              command;
	logic [SIZE_W-1:0] request_bytes;
	logic [IDX_W-1:0]  release_index;
	logic              out_valid;
	logic              out_ready;
	logic [1:0]        status;
	logic [IDX_W-1:0]  granted_index;

	pool_tracker       tracker;
	logic [SIZE_W-1:0] next_sizes [NUM_CLASS_REGS];
	int                burst_left = 0;
	bit                hold_req = 1'b0;
	int                idle_cycles = 0;

	size_class_buffer_pool_allocator_core #(
		.POOL_BUFFERS(POOL_SIZE),
		.SIZE_CLASSES(CLASS_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.request_bytes(request_bytes),
		.release_index(release_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.granted_index(granted_index)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Handshake monitor: config writes, accepted requests, returned results
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) tracker.write_class(cfg_index, cfg_data);
			if (in_valid && in_ready) tracker.note_request(command, request_bytes, release_index);
			if (out_valid && out_ready) tracker.check_result(status_t'(status), granted_index);
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Result receiver: switches between stall patterns, long hold-off on request
	initial begin
		rx_mode_t rx_mode;
		int       mode_left;
		int       hold_left;
		int       tick;
		rx_mode = RX_OPEN;
		mode_left = 0;
		hold_left = 0;
		tick = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				tick++;
				case (rx_mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= (tick % 3 == 0);
				endcase
			end
		end
	end

	// Offer one request; bursts of random length with random gaps between them.
	// Called at a rising edge, returns at the edge where the request is taken.
	task automatic send_item(input logic cmd, input logic [SIZE_W-1:0] bytes,
			input logic [IDX_W-1:0] rel);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid      <= 1'b1;
		command       <= cmd;
		request_bytes <= bytes;
		release_index <= rel;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop offering and wait until every awaited result is back
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	// Write all class size registers from next_sizes
	task automatic load_classes();
		for (int r = 0; r < NUM_CLASS_REGS; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_W'(r);
			cfg_data  <= next_sizes[r];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic pick_setting(input int p);
		case (p)
			0: next_sizes = DEFAULT_BYTES;
			1: foreach (next_sizes[c]) next_sizes[c] = '0;
			2: foreach (next_sizes[c]) next_sizes[c] = '1;
			3: foreach (next_sizes[c]) next_sizes[c] = $urandom();
			4: next_sizes = '{32'd1, 32'd2, 32'd4, 32'd64, 32'd256, 32'd4096, 32'd65536};
			// not ascending, extremes mixed
			default: next_sizes = '{32'd0, 32'hFFFF_FFFF, 32'd1000, 32'd1000,
				32'd5, 32'd5, 32'hFFFF_FFFF};
		endcase
	endtask

	// Request sizes clustered around the current class boundaries
	function automatic logic [SIZE_W-1:0] random_request();
		logic [SIZE_W-1:0] base;
		base = tracker.class_bytes[$urandom_range(0, CLASS_COUNT - 1)];
		case ($urandom_range(0, 7))
			0: return $urandom();
			1: return '0;
			2: return '1;
			3: return base;
			4: return (base == '0) ? base : base - 1;
			5: return (base == '1) ? base : base + 1;
			default: return $urandom_range(0, base);
		endcase
	endfunction

	// Mostly buffers that are held, the rest anywhere in the index range
	function automatic logic [IDX_W-1:0] random_release();
		int held;
		held = tracker.pick_held();
		if (held >= 0 && $urandom_range(0, 9) < 7) return IDX_W'(held);
		return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
	endfunction

	task automatic run_random(input int count);
		int alloc_pct;
		alloc_pct = $urandom_range(40, 80);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 59) == 0) settle();
			if ($urandom_range(0, 99) < alloc_pct)
				send_item(CMD_ALLOC, random_request(), IDX_W'($urandom()));
			else
				send_item(CMD_RELEASE, $urandom(), random_release());
		end
	endtask

	initial begin
		tracker       = new();
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		command       = CMD_ALLOC;
		request_bytes = '0;
		release_index = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: class boundaries at reset sizes, oversize, releases
		send_item(CMD_ALLOC, 32'd0, 7'd127);          // smallest -> 0
		send_item(CMD_ALLOC, 32'd65536, 7'd0);        // exact class 0 size -> 1
		send_item(CMD_ALLOC, 32'd65537, 7'd0);        // one over -> class 1
		send_item(CMD_ALLOC, 32'd1048576, 7'd0);
		send_item(CMD_ALLOC, 32'd4194304, 7'd0);
		send_item(CMD_ALLOC, 32'd8388608, 7'd0);
		send_item(CMD_ALLOC, 32'd16777216, 7'd0);
		send_item(CMD_ALLOC, 32'd33554432, 7'd0);     // last buffer
		send_item(CMD_ALLOC, 32'd33554432, 7'd0);     // scan runs off the end
		send_item(CMD_ALLOC, 32'd33554433, 7'd0);     // larger than every class
		send_item(CMD_ALLOC, 32'hFFFF_FFFF, 7'd127);
		send_item(CMD_RELEASE, 32'hFFFF_FFFF, 7'd70);
		send_item(CMD_RELEASE, 32'd0, 7'd70);         // already free
		send_item(CMD_RELEASE, 32'd0, 7'd71);         // just past the pool
		send_item(CMD_RELEASE, 32'hFFFF_FFFF, 7'd127);
		send_item(CMD_ALLOC, 32'd33554432, 7'd127);
		send_item(CMD_RELEASE, 32'd0, 7'd0);
		send_item(CMD_ALLOC, 32'd0, 7'd0);
		send_item(CMD_RELEASE, 32'd0, 7'd1);
		send_item(CMD_RELEASE, 32'd0, 7'd16);
		send_item(CMD_RELEASE, 32'd0, 7'd48);
		send_item(CMD_RELEASE, 32'd0, 7'd56);
		send_item(CMD_RELEASE, 32'd0, 7'd64);
		send_item(CMD_RELEASE, 32'd0, 7'd68);
		send_item(CMD_RELEASE, 32'd0, 7'd70);

		// Random phases, one class size setting each
		for (int p = 0; p < PHASES; p++) begin
			settle();
			pick_setting(p);
			load_classes();
			// first phase: receiver holds off while requests keep coming
			if (p == 0) hold_req = 1'b1;
			run_random(PHASE_ITEMS);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
